@@ hw/rtl/ntca_pkg.sv @@
// shared constants, codes and types of the ntc thermistor temperature averager
// no dependencies
`default_nettype none

package ntca_pkg;

  localparam int ADC_BITS   = 12;
  localparam int COUNT_BITS = 10;
  localparam int SUM_BITS   = ADC_BITS + COUNT_BITS;
  localparam int LOG_FRAC   = 28;
  localparam int BETA_BITS  = 14;
  localparam int NTEMP_BITS = 16;
  localparam int CFG_BITS   = 16;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [COUNT_BITS-1:0] SAMPLE_COUNT_RST = COUNT_BITS'(10);
  localparam logic [BETA_BITS-1:0]  BETA_RST         = BETA_BITS'(3950);
  localparam logic [NTEMP_BITS-1:0] NTEMP_RST        = NTEMP_BITS'(29815);

  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_BETA         = 2'd1;
  localparam logic [1:0] CFG_NOMINAL_TEMP = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ZERO_MEAN = 2'd1;
  localparam logic [1:0] STAT_CLIP_LOW  = 2'd2;
  localparam logic [1:0] STAT_CLIP_HIGH = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOG_SETUP,
    ST_LOG_SQ,
    ST_LN,
    ST_NB,
    ST_NL,
    ST_DCALC,
    ST_NUM,
    ST_QDIV,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/ntca_div.sv @@
// restoring divider for the mean: sum of codes over number of codes, one bit a cycle
// depends on ntca_pkg
`default_nettype none

module ntca_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [ntca_pkg::SUM_BITS-1:0]   dividend,
  input  wire logic [ntca_pkg::COUNT_BITS-1:0] divisor,
  output logic                                done,
  output logic [ntca_pkg::ADC_BITS-1:0]        quotient
);
  import ntca_pkg::*;

  localparam int CNT_W = $clog2(SUM_BITS + 1);

  logic [COUNT_BITS-1:0] div_r, div_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [SUM_BITS-1:0]   q_r, q_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [COUNT_BITS:0]   cat;
  logic                  ge;
  logic [COUNT_BITS:0]   diff;

  always_comb begin
    cat  = {rem_r, q_r[SUM_BITS-1]};
    ge   = cat >= {1'b0, div_r};
    diff = cat - {1'b0, div_r};
  end

  always_comb begin
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      div_nxt  = divisor;
      rem_nxt  = '0;
      q_nxt    = dividend;
      cnt_nxt  = CNT_W'(SUM_BITS - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits back into its width
      rem_nxt = ge ? diff[COUNT_BITS-1:0] : cat[COUNT_BITS-1:0];
      q_nxt   = {q_r[SUM_BITS-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r[ADC_BITS-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/ntc_thermistor_temperature_averager.sv @@
// Averages ADC codes of an NTC divider and converts the mean to whole degrees Celsius by the
// beta equation. The code that closes a group starts the conversion and the block holds
// in_stall high until the result word is loaded into the output register, after the mean
// divider (22 quotient bits and the hand-over), the two logarithms (one squaring a cycle on
// the shared 32x32 multiplier), the beta terms, the final quotient of nine bits and the load
// of the output register. A zero mean, a curve pole or a result below zero ends the
// conversion early, and a full, stalled output register adds its stall.
// Codes that do not close a group are taken back to back. cfg_ready is always high.
// depends on ntca_pkg and ntca_div
`default_nettype none

module ntc_thermistor_temperature_averager (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [ntca_pkg::ADC_BITS-1:0]   in_adc_code,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_temperature_c,
  output logic [ntca_pkg::ADC_BITS-1:0]        out_average_code,
  output logic [1:0]                          out_status,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [ntca_pkg::CFG_BITS-1:0]   cfg_data
);
  import ntca_pkg::*;

  state_t state_r, state_nxt;

  logic [COUNT_BITS-1:0] scount_r;
  logic [BETA_BITS-1:0]  beta_r;
  logic [NTEMP_BITS-1:0] ntemp_r;

  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] taken_r, taken_nxt;

  logic [ADC_BITS-1:0]   avg_r, avg_nxt;
  logic                  sel_r, sel_nxt;
  logic [LOG_FRAC:0]     m_r, m_nxt;
  logic [31:0]           res_r, res_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [27:0]           ln1_r, ln1_nxt;
  logic signed [28:0]    l_r, l_nxt;
  logic [29:0]           nb_r, nb_nxt;
  logic signed [47:0]    d_r, d_nxt;
  logic [36:0]           t1_r, t1_nxt;
  logic [63:0]           t2_r, t2_nxt;
  logic [63:0]           dd_r, dd_nxt;
  logic [63:0]           rem_r, rem_nxt;
  logic [8:0]            q_r, q_nxt;
  logic [7:0]            temp_r, temp_nxt;
  logic [1:0]            stat_r, stat_nxt;

  logic                  ov_r, ov_nxt;
  logic [7:0]            otemp_r, otemp_nxt;
  logic [ADC_BITS-1:0]   oavg_r, oavg_nxt;
  logic [1:0]            ostat_r, ostat_nxt;

  logic                  accept;
  logic [COUNT_BITS-1:0] target;
  logic [COUNT_BITS:0]   taken_inc;
  logic [SUM_BITS-1:0]   sum_inc;
  logic                  div_start, div_done;
  logic [ADC_BITS-1:0]   div_q;

  logic [ADC_BITS-1:0]   log_x;
  logic [3:0]            log_k;
  logic [31:0]           mul_a, mul_b;
  logic [63:0]           prod;
  logic [LOG_FRAC+1:0]   sq;
  logic [27:0]           l_mag;
  logic [43:0]           nl_mag;
  logic [20:0]           b100;
  logic signed [47:0]    nl;
  logic signed [63:0]    num;
  logic                  qge;

  ntca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_inc),
    .divisor  (taken_inc[COUNT_BITS-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign target    = (scount_r == '0) ? COUNT_BITS'(1) : scount_r;
  assign taken_inc = {1'b0, taken_r} + 1'b1;
  assign sum_inc   = sum_r + SUM_BITS'(in_adc_code);
  assign div_start = accept && (taken_inc >= {1'b0, target});

  // operand selection of the shared multiplier
  always_comb begin
    log_x = sel_r ? avg_r : ADC_BITS'((ADC_BITS + 1)'(1 << ADC_BITS) - {1'b0, avg_r});
    log_k = '0;
    for (int i = 0; i < ADC_BITS; i++) begin
      if (log_x[i]) log_k = 4'(i);
    end
    l_mag = l_r[28] ? 28'(-l_r) : 28'(l_r);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOG_SQ: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      ST_LN: begin
        mul_a = res_r;
        mul_b = LN2_Q32;
      end
      ST_NB: begin
        mul_a = 32'(ntemp_r);
        mul_b = 32'(beta_r);
      end
      ST_NL: begin
        mul_a = 32'(l_mag);
        mul_b = 32'(ntemp_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod   = 64'(mul_a) * 64'(mul_b);
    sq     = prod[2*LOG_FRAC+1:LOG_FRAC];
    nl_mag = prod[43:0];
    nl     = l_r[28] ? -$signed({4'b0, nl_mag}) : $signed({4'b0, nl_mag});
    b100   = 21'(beta_r) * 21'd100;
    num    = $signed({3'b0, t1_r, 24'b0}) - $signed(t2_r);
    qge    = rem_r >= dd_r;
  end

  always_comb begin
    state_nxt = state_r;
    sum_nxt   = sum_r;
    taken_nxt = taken_r;
    avg_nxt   = avg_r;
    sel_nxt   = sel_r;
    m_nxt     = m_r;
    res_nxt   = res_r;
    cnt_nxt   = cnt_r;
    ln1_nxt   = ln1_r;
    l_nxt     = l_r;
    nb_nxt    = nb_r;
    d_nxt     = d_r;
    t1_nxt    = t1_r;
    t2_nxt    = t2_r;
    dd_nxt    = dd_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    temp_nxt  = temp_r;
    stat_nxt  = stat_r;
    ov_nxt    = ov_r && out_stall;
    otemp_nxt = otemp_r;
    oavg_nxt  = oavg_r;
    ostat_nxt = ostat_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (div_start) begin
            sum_nxt   = '0;
            taken_nxt = '0;
            state_nxt = ST_DIV;
          end else begin
            sum_nxt   = sum_inc;
            taken_nxt = taken_inc[COUNT_BITS-1:0];
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          avg_nxt = div_q;
          sel_nxt = 1'b0;
          if (div_q == '0) begin
            temp_nxt  = 8'd0;
            stat_nxt  = STAT_ZERO_MEAN;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_LOG_SETUP;
          end
        end
      end
      ST_LOG_SETUP: begin
        // normalise the mantissa into [1,2)
        m_nxt     = (LOG_FRAC + 1)'({log_x, LOG_FRAC'(0)} >> log_k);
        res_nxt   = {log_k, LOG_FRAC'(0)};
        cnt_nxt   = 5'(LOG_FRAC - 1);
        state_nxt = ST_LOG_SQ;
      end
      ST_LOG_SQ: begin
        if (sq[LOG_FRAC+1]) begin
          m_nxt             = sq[LOG_FRAC+1:1];
          res_nxt[cnt_r]    = 1'b1;
        end else begin
          m_nxt = sq[LOG_FRAC:0];
        end
        if (cnt_r == '0) begin
          state_nxt = ST_LN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_LN: begin
        if (!sel_r) begin
          ln1_nxt   = prod[63:36];
          sel_nxt   = 1'b1;
          state_nxt = ST_LOG_SETUP;
        end else begin
          l_nxt     = $signed({1'b0, ln1_r}) - $signed({1'b0, prod[63:36]});
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        nb_nxt    = prod[29:0];
        state_nxt = ST_NL;
      end
      ST_NL: begin
        d_nxt     = $signed({3'b0, b100, 24'b0}) + nl;
        state_nxt = ST_DCALC;
      end
      ST_DCALC: begin
        if (d_r[47] || d_r == '0) begin
          // beyond the pole of the curve: hot without bound
          temp_nxt  = 8'd255;
          stat_nxt  = STAT_CLIP_HIGH;
          state_nxt = ST_OUT;
        end else begin
          t1_nxt    = 37'(nb_r) * 37'd100;
          t2_nxt    = 64'(d_r[46:0]) * 64'd27265;
          dd_nxt    = 64'(d_r[46:0]) * 64'd100;
          state_nxt = ST_NUM;
        end
      end
      ST_NUM: begin
        if (num[63]) begin
          temp_nxt  = 8'd0;
          stat_nxt  = STAT_CLIP_LOW;
          state_nxt = ST_OUT;
        end else begin
          rem_nxt   = 64'(num);
          dd_nxt    = dd_r << 8;
          q_nxt     = '0;
          cnt_nxt   = 5'd8;
          state_nxt = ST_QDIV;
        end
      end
      ST_QDIV: begin
        if (qge) rem_nxt = rem_r - dd_r;
        q_nxt  = {q_r[7:0], qge};
        dd_nxt = dd_r >> 1;
        if (cnt_r == '0) begin
          // quotient of nine bits: the top bit means above 255
          if (q_r[7]) begin
            temp_nxt = 8'd255;
            stat_nxt = STAT_CLIP_HIGH;
          end else begin
            temp_nxt = {q_r[6:0], qge};
            stat_nxt = STAT_OK;
          end
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          otemp_nxt = temp_r;
          oavg_nxt  = avg_r;
          ostat_nxt = stat_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      sum_r    <= '0;
      taken_r  <= '0;
      ov_r     <= 1'b0;
      scount_r <= SAMPLE_COUNT_RST;
      beta_r   <= BETA_RST;
      ntemp_r  <= NTEMP_RST;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      taken_r <= taken_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SAMPLE_COUNT: scount_r <= cfg_data[COUNT_BITS-1:0];
          CFG_BETA:         beta_r   <= cfg_data[BETA_BITS-1:0];
          CFG_NOMINAL_TEMP: ntemp_r  <= cfg_data[NTEMP_BITS-1:0];
          default: ;
        endcase
      end
    end
    avg_r   <= avg_nxt;
    sel_r   <= sel_nxt;
    m_r     <= m_nxt;
    res_r   <= res_nxt;
    cnt_r   <= cnt_nxt;
    ln1_r   <= ln1_nxt;
    l_r     <= l_nxt;
    nb_r    <= nb_nxt;
    d_r     <= d_nxt;
    t1_r    <= t1_nxt;
    t2_r    <= t2_nxt;
    dd_r    <= dd_nxt;
    rem_r   <= rem_nxt;
    q_r     <= q_nxt;
    temp_r  <= temp_nxt;
    stat_r  <= stat_nxt;
    otemp_r <= otemp_nxt;
    oavg_r  <= oavg_nxt;
    ostat_r <= ostat_nxt;
  end

  assign out_valid         = ov_r;
  assign out_temperature_c = otemp_r;
  assign out_average_code  = oavg_r;
  assign out_status        = ostat_r;

endmodule

`default_nettype wire
